### rtl/rtbs_pkg.sv
package rtbs_pkg;

	// Store geometry
	localparam int MAX_ROWS     = 1024;
	localparam int MAX_FEATURES = 16;
	localparam int ROW_W        = $clog2(MAX_ROWS);
	localparam int FEAT_W       = $clog2(MAX_FEATURES);
	localparam int CELL_AW      = ROW_W + FEAT_W;

	// Field and datapath widths
	localparam int VAL_W   = 32;
	localparam int TGT_W   = 16;
	localparam int SCORE_W = 52;
	localparam int SUM_W   = 27;
	localparam int MAG_W   = SUM_W - 1;
	localparam int CNT_W   = 11;
	localparam int POS_W   = 12;
	localparam int NF_W    = 5;
	localparam int CFG_W   = 11;

	// Configuration register indexes
	localparam logic REG_NUM_FEATURES = 1'b0;
	localparam logic REG_NUM_ROWS     = 1'b1;

	typedef logic [SCORE_W-1:0] score_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [CNT_W-1:0] cnt_t;

endpackage

### rtl/regression_tree_best_split.sv
// Cells are taken one per cycle while the block is idle and written to the cell store in that cycle.
// After a last cell the search runs: it totals the targets, then per feature it seeds the order,
// runs ceil(log2 n) merge passes and scores each boundary between distinct values, with two
// 52-step divisions per scored one.
// No cell is taken while a search runs or while its result waits for the result register.
// Reset clears control state and sets 1 feature and 0 rows; the stores are not cleared.
module regression_tree_best_split (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rtbs_pkg::ROW_W-1:0]          row_index,
	input  logic [rtbs_pkg::FEAT_W-1:0]         feature_index,
	input  logic signed [rtbs_pkg::VAL_W-1:0]   feature_value,
	input  logic signed [rtbs_pkg::TGT_W-1:0]   target_value,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                found,
	output logic [rtbs_pkg::FEAT_W-1:0]         best_feature,
	output logic signed [rtbs_pkg::VAL_W-1:0]   threshold,
	output logic [rtbs_pkg::SCORE_W-1:0]        best_score,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [rtbs_pkg::CFG_W-1:0]          cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_TOT_RD, S_TOT_ACC, S_FEAT, S_IDN, S_PASS, S_MSET,
		S_LA, S_LA1, S_LA2, S_LB, S_LB1, S_LB2, S_MOUT,
		S_SC0, S_SC1, S_SC2, S_SN0, S_SN1, S_SN2,
		S_SQL, S_DVL, S_WL, S_SQR, S_DVR, S_WR, S_CMP, S_DONE
	} state_t;

	localparam int PW = rtbs_pkg::POS_W;
	localparam int RW = rtbs_pkg::ROW_W;

	state_t                              state_q;
	logic [rtbs_pkg::NF_W-1:0]           nf_q;
	rtbs_pkg::cnt_t                      n_q;
	rtbs_pkg::cnt_t                      i_q;
	logic [rtbs_pkg::NF_W-1:0]           f_q;
	logic [PW-1:0]                       width_q, lo_q, mid_q, hi_q, a_q, b_q, k_q;
	logic                                src_q, init_q;
	logic [RW-1:0]                       ha_row_q, hb_row_q, cr_q, nr_q;
	logic signed [rtbs_pkg::VAL_W-1:0]   ha_val_q, hb_val_q, cv_q;
	rtbs_pkg::sum_t                      total_q, lsum_q;
	rtbs_pkg::score_t                    sq_q, acc_q, score_q, bscore_q;
	logic                                bv_q;
	logic [rtbs_pkg::FEAT_W-1:0]         bfeat_q;
	logic signed [rtbs_pkg::VAL_W-1:0]   bthr_q;

	logic                                in_acc;
	logic [rtbs_pkg::VAL_W-1:0]          feat_rd;
	logic [rtbs_pkg::TGT_W-1:0]          tgt_rd;
	logic [RW-1:0]                       ord0_rd, ord1_rd, ord_rd;
	logic [RW-1:0]                       ord_raddr, ord_waddr, ord_wdata, tgt_raddr;
	logic                                ord0_we, ord1_we, mwrite;
	logic                                a_ok, b_ok, take_b;
	logic [PW-1:0]                       n_ext, w2, lo_next;
	rtbs_pkg::cnt_t                      lc, rc;
	rtbs_pkg::sum_t                      rsum, abs_l, abs_r, tgt_ext;
	logic [rtbs_pkg::MAG_W-1:0]          mul_a;
	rtbs_pkg::score_t                    product;
	logic                                div_start, div_done;
	rtbs_pkg::score_t                    div_quo;
	rtbs_pkg::cnt_t                      div_den;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// Configuration registers, clamped to the store sizes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nf_q <= rtbs_pkg::NF_W'(1);
			n_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rtbs_pkg::REG_NUM_FEATURES: begin
					nf_q <= (cfg_data[rtbs_pkg::NF_W-1:0] >
					         rtbs_pkg::NF_W'(rtbs_pkg::MAX_FEATURES))
					        ? rtbs_pkg::NF_W'(rtbs_pkg::MAX_FEATURES)
					        : cfg_data[rtbs_pkg::NF_W-1:0];
				end
				rtbs_pkg::REG_NUM_ROWS: begin
					n_q <= (cfg_data > rtbs_pkg::CFG_W'(rtbs_pkg::MAX_ROWS))
					       ? rtbs_pkg::CNT_W'(rtbs_pkg::MAX_ROWS)
					       : rtbs_pkg::CNT_W'(cfg_data);
				end
				default: begin
					n_q <= n_q;
				end
			endcase
		end
	end

	// Stores: cell values, row targets and two banks of row order.
	rtbs_ram #(.W(rtbs_pkg::VAL_W), .D(rtbs_pkg::MAX_ROWS * rtbs_pkg::MAX_FEATURES)) u_cells (
		.clk   (clk),
		.we    (in_acc),
		.waddr ({row_index, feature_index}),
		.wdata (feature_value),
		.raddr ({ord_rd, f_q[rtbs_pkg::FEAT_W-1:0]}),
		.rdata (feat_rd)
	);

	rtbs_ram #(.W(rtbs_pkg::TGT_W), .D(rtbs_pkg::MAX_ROWS)) u_tgt (
		.clk   (clk),
		.we    (in_acc && (feature_index == '0)),
		.waddr (row_index),
		.wdata (target_value),
		.raddr (tgt_raddr),
		.rdata (tgt_rd)
	);

	rtbs_ram #(.W(RW), .D(rtbs_pkg::MAX_ROWS)) u_ord0 (
		.clk   (clk),
		.we    (ord0_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (ord_raddr),
		.rdata (ord0_rd)
	);

	rtbs_ram #(.W(RW), .D(rtbs_pkg::MAX_ROWS)) u_ord1 (
		.clk   (clk),
		.we    (ord1_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (ord_raddr),
		.rdata (ord1_rd)
	);

	rtbs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sq_q),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Merge selection: take the right run when the left run is used up or the right head is strictly smaller.
	assign ord_rd  = src_q ? ord1_rd : ord0_rd;
	assign a_ok    = a_q < mid_q;
	assign b_ok    = b_q < hi_q;
	assign take_b  = b_ok && (!a_ok || (hb_val_q < ha_val_q));
	assign n_ext   = PW'(n_q);
	assign w2      = {width_q[PW-2:0], 1'b0};
	assign lo_next = lo_q + w2;

	// Order bank writes: seeding writes bank 0, merges write the other bank.
	assign mwrite    = (state_q == S_MOUT) && (k_q != hi_q);
	assign ord_waddr = (state_q == S_IDN) ? i_q[RW-1:0] : k_q[RW-1:0];
	assign ord_wdata = (state_q == S_IDN) ? i_q[RW-1:0]
	                 : (take_b ? hb_row_q : ha_row_q);
	assign ord0_we   = ((state_q == S_IDN) && (i_q != n_q)) || (mwrite && src_q);
	assign ord1_we   = mwrite && !src_q;

	// Read addresses for the order banks and the target store.
	always_comb begin
		case (state_q)
			S_LB:    ord_raddr = b_q[RW-1:0];
			S_SC0:   ord_raddr = '0;
			S_SN0:   ord_raddr = RW'(i_q + 1'b1);
			default: ord_raddr = a_q[RW-1:0];
		endcase
		case (state_q)
			S_SN0:   tgt_raddr = cr_q;
			default: tgt_raddr = i_q[RW-1:0];
		endcase
	end

	// Split arithmetic: side counts, right sum and magnitudes for squaring.
	assign lc        = i_q + 1'b1;
	assign rc        = n_q - lc;
	assign rsum      = total_q - lsum_q;
	assign abs_l     = lsum_q[rtbs_pkg::SUM_W-1] ? -lsum_q : lsum_q;
	assign abs_r     = rsum[rtbs_pkg::SUM_W-1] ? -rsum : rsum;
	assign mul_a     = (state_q == S_SQL) ? abs_l[rtbs_pkg::MAG_W-1:0]
	                                      : abs_r[rtbs_pkg::MAG_W-1:0];
	assign product   = rtbs_pkg::SCORE_W'(mul_a) * rtbs_pkg::SCORE_W'(mul_a);
	assign tgt_ext   = rtbs_pkg::SUM_W'(signed'(tgt_rd));
	assign div_start = (state_q == S_DVL) || (state_q == S_DVR);
	assign div_den   = (state_q == S_DVL) ? lc : rc;

	// Search sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			i_q       <= '0;
			f_q       <= '0;
			width_q   <= '0;
			lo_q      <= '0;
			mid_q     <= '0;
			hi_q      <= '0;
			a_q       <= '0;
			b_q       <= '0;
			k_q       <= '0;
			src_q     <= 1'b0;
			init_q    <= 1'b0;
			ha_row_q  <= '0;
			hb_row_q  <= '0;
			cr_q      <= '0;
			nr_q      <= '0;
			ha_val_q  <= '0;
			hb_val_q  <= '0;
			cv_q      <= '0;
			total_q   <= '0;
			lsum_q    <= '0;
			sq_q      <= '0;
			acc_q     <= '0;
			score_q   <= '0;
			bv_q      <= 1'b0;
			bscore_q  <= '0;
			bfeat_q   <= '0;
			bthr_q    <= '0;
			out_valid <= 1'b0;
			found     <= 1'b0;
			best_feature <= '0;
			threshold <= '0;
			best_score <= '0;
		end else begin
			if (out_ready && (state_q != S_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && last) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					bv_q     <= 1'b0;
					bscore_q <= '0;
					bfeat_q  <= '0;
					bthr_q   <= '0;
					f_q      <= '0;
					total_q  <= '0;
					i_q      <= '0;
					if ((n_q < rtbs_pkg::CNT_W'(2)) || (nf_q == '0)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_TOT_RD;
					end
				end
				S_TOT_RD: begin
					state_q <= (i_q == n_q) ? S_FEAT : S_TOT_ACC;
				end
				S_TOT_ACC: begin
					total_q <= total_q + tgt_ext;
					i_q     <= i_q + 1'b1;
					state_q <= S_TOT_RD;
				end
				S_FEAT: begin
					i_q     <= '0;
					state_q <= S_IDN;
				end
				S_IDN: begin
					if (i_q == n_q) begin
						width_q <= PW'(1);
						src_q   <= 1'b0;
						state_q <= S_PASS;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_PASS: begin
					if (width_q >= n_ext) begin
						i_q     <= '0;
						lsum_q  <= '0;
						state_q <= S_SC0;
					end else begin
						lo_q    <= '0;
						state_q <= S_MSET;
					end
				end
				S_MSET: begin
					mid_q   <= ((lo_q + width_q) > n_ext) ? n_ext : (lo_q + width_q);
					hi_q    <= (lo_next > n_ext) ? n_ext : lo_next;
					b_q     <= ((lo_q + width_q) > n_ext) ? n_ext : (lo_q + width_q);
					a_q     <= lo_q;
					k_q     <= lo_q;
					init_q  <= 1'b1;
					state_q <= S_LA;
				end
				S_LA: begin
					if (a_ok) begin
						state_q <= S_LA1;
					end else begin
						state_q <= init_q ? S_LB : S_MOUT;
					end
				end
				S_LA1: begin
					ha_row_q <= ord_rd;
					state_q  <= S_LA2;
				end
				S_LA2: begin
					ha_val_q <= feat_rd;
					state_q  <= init_q ? S_LB : S_MOUT;
				end
				S_LB: begin
					init_q  <= 1'b0;
					state_q <= b_ok ? S_LB1 : S_MOUT;
				end
				S_LB1: begin
					hb_row_q <= ord_rd;
					state_q  <= S_LB2;
				end
				S_LB2: begin
					hb_val_q <= feat_rd;
					state_q  <= S_MOUT;
				end
				S_MOUT: begin
					if (k_q == hi_q) begin
						if (lo_next >= n_ext) begin
							src_q   <= !src_q;
							width_q <= w2;
							state_q <= S_PASS;
						end else begin
							lo_q    <= lo_next;
							state_q <= S_MSET;
						end
					end else begin
						k_q <= k_q + 1'b1;
						if (take_b) begin
							b_q     <= b_q + 1'b1;
							state_q <= S_LB;
						end else begin
							a_q     <= a_q + 1'b1;
							state_q <= S_LA;
						end
					end
				end
				S_SC0: begin
					state_q <= S_SC1;
				end
				S_SC1: begin
					cr_q    <= ord_rd;
					state_q <= S_SC2;
				end
				S_SC2: begin
					cv_q    <= feat_rd;
					state_q <= S_SN0;
				end
				S_SN0: begin
					if ((PW'(i_q) + 1'b1) >= n_ext) begin
						f_q <= f_q + 1'b1;
						state_q <= ((f_q + 1'b1) == nf_q) ? S_DONE : S_FEAT;
					end else begin
						state_q <= S_SN1;
					end
				end
				S_SN1: begin
					nr_q    <= ord_rd;
					lsum_q  <= lsum_q + tgt_ext;
					state_q <= S_SN2;
				end
				S_SN2: begin
					if (cv_q == signed'(feat_rd)) begin
						cr_q    <= nr_q;
						i_q     <= i_q + 1'b1;
						state_q <= S_SN0;
					end else begin
						hb_val_q <= feat_rd;
						state_q  <= S_SQL;
					end
				end
				S_SQL: begin
					sq_q    <= product;
					state_q <= S_DVL;
				end
				S_DVL: begin
					state_q <= S_WL;
				end
				S_WL: begin
					if (div_done) begin
						acc_q   <= div_quo;
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					sq_q    <= product;
					state_q <= S_DVR;
				end
				S_DVR: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (div_done) begin
						score_q <= acc_q + div_quo;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (!bv_q || (score_q > bscore_q)) begin
						bv_q     <= 1'b1;
						bscore_q <= score_q;
						bfeat_q  <= f_q[rtbs_pkg::FEAT_W-1:0];
						bthr_q   <= cv_q;
					end
					cr_q    <= nr_q;
					cv_q    <= hb_val_q;
					i_q     <= i_q + 1'b1;
					state_q <= S_SN0;
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						found        <= bv_q;
						best_feature <= bfeat_q;
						threshold    <= bthr_q;
						best_score   <= bscore_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/rtbs_ram.sv
module rtbs_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/rtbs_div.sv
module rtbs_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  rtbs_pkg::score_t        num,
	input  rtbs_pkg::cnt_t          den,
	output logic                    done,
	output rtbs_pkg::score_t        quo
);

	localparam int STEP_W = $clog2(rtbs_pkg::SCORE_W);

	logic                        busy_q;
	logic [STEP_W-1:0]           step_q;
	rtbs_pkg::score_t            num_q;
	rtbs_pkg::cnt_t              den_q;
	rtbs_pkg::cnt_t              rem_q;
	logic [rtbs_pkg::CNT_W:0]    trial;
	logic                        fits;

	// Restoring division, one quotient bit per cycle.
	assign trial = {rem_q, num_q[rtbs_pkg::SCORE_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign quo   = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q  <= fits ? rtbs_pkg::CNT_W'(trial - {1'b0, den_q})
				               : rtbs_pkg::CNT_W'(trial);
				num_q  <= {num_q[rtbs_pkg::SCORE_W-2:0], fits};
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(rtbs_pkg::SCORE_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/rtbs_check.sv
module rtbs_check (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                last,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                found,
	input logic [rtbs_pkg::FEAT_W-1:0]         best_feature,
	input logic signed [rtbs_pkg::VAL_W-1:0]   threshold,
	input logic [rtbs_pkg::SCORE_W-1:0]        best_score
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) &&
		$stable(best_feature) && $stable(threshold) && $stable(best_score))
		else $error("result beat changed while stalled");

	// The search owns the block after a last cell.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("cell taken during a search");

	// No split means all result fields are zero.
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> best_feature == '0 && threshold == '0 &&
		best_score == '0)
		else $error("nonzero fields without a split");

	// A new result appears only at the end of a search.
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a search");

endmodule

bind regression_tree_best_split rtbs_check u_rtbs_check (.*);
